// ----- rtl/beb_pkg.sv -----
// Shared types and constants for the binary exponential backoff core.
package beb_pkg;

  localparam int unsigned RND_W    = 32;
  localparam int unsigned WIN_W    = 17;
  localparam int unsigned TRIES_W  = 9;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W    = 5;   // counts the RND_W divide steps

  typedef enum logic [1:0] {
    FUNC_TX      = 2'd0,
    FUNC_SUCCESS = 2'd1,
    FUNC_FAIL    = 2'd2,
    FUNC_RESET   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RETRY_LIMIT = 2'd0,
    REG_MAX_WINDOW  = 2'd1,
    REG_MIN_WINDOW  = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  localparam logic [7:0]         RETRY_LIMIT_RST = 8'd7;
  localparam logic [CFG_W-1:0]   MAX_WINDOW_RST  = 16'hFFFF;
  localparam logic [CFG_W-1:0]   MIN_WINDOW_RST  = 16'd1;
  localparam logic [TRIES_W-1:0] TRIES_ONE       = 9'd1;
  localparam logic [TRIES_W-1:0] TRIES_SAT       = 9'h1FF;

  typedef struct packed {
    logic [1:0]       func;
    logic [RND_W-1:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic               granted;
    logic [WIN_W-1:0]   backoff_slot;
    logic [WIN_W-1:0]   window_now;
    logic [TRIES_W-1:0] tries_now;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage

// ----- rtl/beb_ctrl.sv -----
// Controller: sequences accept, the serial remainder and the output register.
module beb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  beb_pkg::dp_sts_t sts,
  output beb_pkg::dp_cmd_t cmd
);

  beb_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      beb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_div ? beb_pkg::ST_DIV : beb_pkg::ST_DONE;
        end
      end
      beb_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = beb_pkg::ST_DONE;
        end
      end
      beb_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = beb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = beb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      beb_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      beb_pkg::ST_DIV:  cmd.div_step = 1'b1;
      beb_pkg::ST_DONE: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= beb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while held");
  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == beb_pkg::ST_DIV && sts.div_done) |=> state_r == beb_pkg::ST_DONE)
    else $error("divide end not followed by done");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r != beb_pkg::ST_IDLE)
    else $error("accepted word did not occupy the controller");
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == beb_pkg::ST_DONE))
    else $error("output valid raised outside done state");
`endif

endmodule

// ----- rtl/beb_dp.sv -----
// Datapath: window/tries state, config registers, serial remainder, output register.
module beb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [beb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [beb_pkg::CFG_W-1:0]           cfg_wdata,
  input  beb_pkg::in_word_t                   in_data,
  input  beb_pkg::dp_cmd_t                    cmd,
  output beb_pkg::dp_sts_t                    sts,
  output beb_pkg::out_word_t                  out_data
);

  logic [7:0]                      retry_limit_r;
  logic [beb_pkg::CFG_W-1:0]       max_window_r;
  logic [beb_pkg::CFG_W-1:0]       min_window_r;
  logic [beb_pkg::WIN_W-1:0]       window_r, window_nxt;
  logic [beb_pkg::TRIES_W-1:0]     tries_r, tries_nxt;
  logic                            grant_r;
  logic                            grant;
  logic [beb_pkg::WIN_W-1:0]       rem_r;
  logic [beb_pkg::RND_W-1:0]       dvd_r;
  logic [beb_pkg::CNT_W-1:0]       cnt_r;
  logic [beb_pkg::WIN_W:0]         trial;
  logic [beb_pkg::WIN_W:0]         trial_sub;
  logic [beb_pkg::WIN_W-1:0]       rem_nxt;
  logic [beb_pkg::WIN_W-1:0]       slot;
  beb_pkg::out_word_t              out_r;

  assign grant = (in_data.func == beb_pkg::FUNC_TX) &&
                 ({1'b0, tries_r} <= {2'b00, retry_limit_r});

  assign sts.need_div = grant;
  assign sts.div_done = (cnt_r == '1);

  // event update of window and try counter
  always_comb begin
    window_nxt = window_r;
    tries_nxt  = tries_r;
    unique case (in_data.func)
      beb_pkg::FUNC_TX: ;
      beb_pkg::FUNC_SUCCESS, beb_pkg::FUNC_RESET: begin
        tries_nxt  = beb_pkg::TRIES_ONE;
        window_nxt = {1'b0, min_window_r};
      end
      beb_pkg::FUNC_FAIL: begin
        if (tries_r != beb_pkg::TRIES_SAT) begin
          tries_nxt = tries_r + 1'b1;
        end
        if (window_r < {1'b0, max_window_r}) begin
          window_nxt = {window_r[beb_pkg::WIN_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // restoring remainder, one dividend bit per step
  assign trial     = {rem_r, dvd_r[beb_pkg::RND_W-1]};
  assign trial_sub = trial - {1'b0, window_r};
  assign rem_nxt   = (trial >= {1'b0, window_r}) ? trial_sub[beb_pkg::WIN_W-1:0]
                                                 : trial[beb_pkg::WIN_W-1:0];

  // zero window draws slot 0
  assign slot = (grant_r && (window_r != '0)) ? rem_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= beb_pkg::RETRY_LIMIT_RST;
      max_window_r  <= beb_pkg::MAX_WINDOW_RST;
      min_window_r  <= beb_pkg::MIN_WINDOW_RST;
      window_r      <= {1'b0, beb_pkg::MIN_WINDOW_RST};
      tries_r       <= beb_pkg::TRIES_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        beb_pkg::REG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[7:0];
        beb_pkg::REG_MAX_WINDOW:  max_window_r  <= cfg_wdata;
        beb_pkg::REG_MIN_WINDOW: begin
          min_window_r <= cfg_wdata;
          window_r     <= {1'b0, cfg_wdata};
        end
        default: ;
      endcase
    end else if (cmd.accept) begin
      window_r <= window_nxt;
      tries_r  <= tries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      grant_r <= grant;
      dvd_r   <= in_data.random_value;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[beb_pkg::RND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.granted      <= grant_r;
      out_r.backoff_slot <= slot;
      out_r.window_now   <= window_r;
      out_r.tries_now    <= tries_r;
    end
  end

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    window_r <= 17'd131068)
    else $error("window exceeded doubling bound");
  a_rem_below_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && grant_r && window_r != '0) |-> rem_r < window_r)
    else $error("remainder not below window");
`endif

endmodule

// ----- rtl/binary_exponential_backoff_core.sv -----
// Binary exponential backoff core: contention window and try counter policy.
// Input channel (in_valid/in_stall/in_data) carries one event word: func and a
// 32-bit random word. Each accepted word yields exactly one result word on the
// output channel (out_valid/out_stall/out_data): grant flag, backoff slot,
// window and try count after the event.
// One word is processed at a time. A granted transmit request runs a serial
// remainder of the random word by the window, one bit per cycle, in the
// divide state before the done state. Refused requests and other events skip
// the divide state and go straight from accept to the done state.
// The output register lets the core accept a new word while the previous
// result is still stalled; that new word then waits in the done state until
// the register is free.
// cfg_we/cfg_index/cfg_wdata write retry_limit (0), max_window (1) and
// min_window (2); writing min_window also reloads the window. Write only idle.
// Synchronous active-low reset restores retry_limit 7, max_window 65535,
// min_window 1, window 1 and tries 1, and empties the output register.
module binary_exponential_backoff_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  beb_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output beb_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [beb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [beb_pkg::CFG_W-1:0]           cfg_wdata
);

  beb_pkg::dp_cmd_t cmd;
  beb_pkg::dp_sts_t sts;

  beb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  beb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
